### design/msp_pkg.sv
// Shared types and constants for the matrix saddle point finder.
`timescale 1ns / 1ps

package msp_pkg;

  // Fixed field widths of the result transaction
  localparam int IDX_W = 3;
  localparam int VAL_W = 16;

  // At most this many saddle points are reported for one matrix
  localparam int RESULT_LIMIT = 16;
  localparam int HIT_CNT_W    = 5;

  // Entries held between the scanner and the result stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_SCAN = 2'b10
  } front_state_t;

  typedef enum logic {
    ENTRY_HIT = 1'b0,
    ENTRY_END = 1'b1
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t             kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } scan_entry_t;

  typedef struct packed {
    logic        push;
    scan_entry_t entry;
  } queue_wr_t;

  typedef struct packed {
    logic pop_one;
    logic pop_two;
  } queue_rd_t;

  typedef struct packed {
    logic full;
    logic has_one;
    logic has_two;
  } queue_st_t;

endpackage

### design/msp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module msp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/msp_front.sv
// Front end: loads matrix elements, tracks row minima and column maxima, scans for saddle points.
`timescale 1ns / 1ps

module msp_front
  import msp_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VAL_W-1:0] element,
  output logic                    busy,
  output queue_wr_t               q_wr,
  input  logic                    q_full
);

  localparam int CELLS = ROWS * COLS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

  front_state_t state_r, state_nxt;

  // Load position
  logic [RW-1:0] ld_row_r;
  logic [CW-1:0] ld_col_r;
  logic [AW-1:0] ld_addr_r;

  // Scan read position and compare stage
  logic [RW-1:0]  sc_row_r;
  logic [CW-1:0]  sc_col_r;
  logic [AW-1:0]  sc_addr_r;
  logic           sc_issue_r;
  logic           b_vld_r;
  logic [RW-1:0]  b_row_r;
  logic [CW-1:0]  b_col_r;
  logic [HIT_CNT_W-1:0] hits_r;

  logic signed [VAL_W-1:0] rmin_r [ROWS];
  logic signed [VAL_W-1:0] cmax_r [COLS];

  logic                    accept;
  logic                    scanning;
  logic [RW-1:0]           rmin_idx;
  logic [CW-1:0]           cmax_idx;
  logic signed [VAL_W-1:0] rmin_rd;
  logic signed [VAL_W-1:0] cmax_rd;
  logic [VAL_W-1:0]        ram_q;
  logic signed [VAL_W-1:0] cand;
  logic                    b_hit;
  logic                    stall;
  logic                    push_hit;
  logic                    limit_hit;
  logic                    push_end;
  logic                    rd_en;
  logic                    ld_last_col;
  logic                    ld_last_row;
  logic                    sc_last_col;
  logic                    sc_last_row;

  assign scanning = (state_r == ST_SCAN);
  assign accept   = start && (state_r == ST_LOAD);
  assign busy     = scanning;

  assign ld_last_col = (ld_col_r == CW'(COLS - 1));
  assign ld_last_row = (ld_row_r == RW'(ROWS - 1));
  assign sc_last_col = (sc_col_r == CW'(COLS - 1));
  assign sc_last_row = (sc_row_r == RW'(ROWS - 1));

  // Share one read port on each extreme table between load and scan
  assign rmin_idx = scanning ? b_row_r : ld_row_r;
  assign cmax_idx = scanning ? b_col_r : ld_col_r;
  assign rmin_rd  = rmin_r[rmin_idx];
  assign cmax_rd  = cmax_r[cmax_idx];

  // Classify the element that the RAM returned
  assign cand      = $signed(ram_q);
  assign b_hit     = scanning && b_vld_r && (cand == rmin_rd) && (cand == cmax_rd);
  assign stall     = b_hit && q_full;
  assign push_hit  = b_hit && !q_full;
  assign limit_hit = push_hit && (hits_r == HIT_CNT_W'(RESULT_LIMIT - 1));
  assign push_end  = scanning && !sc_issue_r && !b_vld_r && !q_full;
  assign rd_en     = scanning && sc_issue_r && !stall && !limit_hit;

  msp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (ld_addr_r),
    .wr_data (element),
    .rd_en   (rd_en),
    .rd_addr (sc_addr_r),
    .rd_data (ram_q)
  );

  // Queue write
  always_comb begin
    q_wr.push        = push_hit || push_end;
    q_wr.entry.kind  = push_hit ? ENTRY_HIT : ENTRY_END;
    q_wr.entry.row   = push_hit ? IDX_W'(b_row_r) : '0;
    q_wr.entry.col   = push_hit ? IDX_W'(b_col_r) : '0;
    q_wr.entry.value = push_hit ? cand : '0;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept && ld_last_col && ld_last_row) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (push_end) begin
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      ld_row_r   <= '0;
      ld_col_r   <= '0;
      ld_addr_r  <= '0;
      sc_issue_r <= 1'b0;
      b_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Advance load position
      if (accept) begin
        if (ld_last_col) begin
          ld_col_r <= '0;
          if (ld_last_row) begin
            ld_row_r  <= '0;
            ld_addr_r <= '0;
          end else begin
            ld_row_r  <= ld_row_r + 1'b1;
            ld_addr_r <= ld_addr_r + 1'b1;
          end
        end else begin
          ld_col_r  <= ld_col_r + 1'b1;
          ld_addr_r <= ld_addr_r + 1'b1;
        end
      end
      // Arm, advance or stop the scan
      if (accept && ld_last_col && ld_last_row) begin
        sc_issue_r <= 1'b1;
        b_vld_r    <= 1'b0;
      end else if (limit_hit) begin
        sc_issue_r <= 1'b0;
        b_vld_r    <= 1'b0;
      end else if (scanning && !stall) begin
        b_vld_r <= sc_issue_r;
        if (sc_issue_r && sc_last_col && sc_last_row) begin
          sc_issue_r <= 1'b0;
        end
      end
    end
  end

  // Scan position, hit count and extreme tables
  always_ff @(posedge clk) begin
    if (accept && ld_last_col && ld_last_row) begin
      sc_row_r  <= '0;
      sc_col_r  <= '0;
      sc_addr_r <= '0;
      hits_r    <= '0;
    end else if (scanning) begin
      if (push_hit) begin
        hits_r <= hits_r + 1'b1;
      end
      if (rd_en) begin
        b_row_r   <= sc_row_r;
        b_col_r   <= sc_col_r;
        sc_addr_r <= sc_addr_r + 1'b1;
        if (sc_last_col) begin
          sc_col_r <= '0;
          sc_row_r <= sc_row_r + 1'b1;
        end else begin
          sc_col_r <= sc_col_r + 1'b1;
        end
      end
    end
    if (accept) begin
      if (ld_col_r == '0 || element < rmin_rd) begin
        rmin_r[ld_row_r] <= element;
      end
      if (ld_row_r == '0 || element > cmax_rd) begin
        cmax_r[ld_col_r] <= element;
      end
    end
  end

endmodule

### design/msp_queue.sv
// Short shift queue of scan entries between the scanner and the result stage.
`timescale 1ns / 1ps

module msp_queue
  import msp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  queue_wr_t   wr,
  input  queue_rd_t   rd,
  output queue_st_t   st,
  output scan_entry_t head0,
  output scan_entry_t head1
);

  scan_entry_t slot_r   [QUEUE_DEPTH];
  scan_entry_t slot_nxt [QUEUE_DEPTH];
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt, cnt_after;
  logic [QUEUE_CNT_W-1:0] pop_n;

  assign pop_n     = rd.pop_two ? QUEUE_CNT_W'(2) : (rd.pop_one ? QUEUE_CNT_W'(1) : '0);
  assign cnt_after = cnt_r - pop_n;
  assign cnt_nxt   = cnt_after + QUEUE_CNT_W'(wr.push);

  // Shift down by the number popped, then append the new entry
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      slot_nxt[k] = slot_r[k];
      if (rd.pop_two) begin
        if (k + 2 < QUEUE_DEPTH) begin
          slot_nxt[k] = slot_r[(k + 2) % QUEUE_DEPTH];
        end
      end else if (rd.pop_one) begin
        if (k + 1 < QUEUE_DEPTH) begin
          slot_nxt[k] = slot_r[(k + 1) % QUEUE_DEPTH];
        end
      end
    end
    if (wr.push) begin
      slot_nxt[cnt_after[QUEUE_IDX_W-1:0]] = wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      slot_r[k] <= slot_nxt[k];
    end
  end

  assign st.full    = (cnt_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign st.has_one = (cnt_r != '0);
  assign st.has_two = (cnt_r >= QUEUE_CNT_W'(2));
  assign head0      = slot_r[0];
  assign head1      = slot_r[1];

endmodule

### design/msp_back.sv
// Back end: turns scan entries into result transactions and marks the last one.
`timescale 1ns / 1ps

module msp_back
  import msp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  queue_st_t               st,
  input  scan_entry_t             head0,
  input  scan_entry_t             head1,
  output queue_rd_t               rd,
  output logic                    out_valid,
  output logic                    out_found,
  output logic [IDX_W-1:0]        out_row_index,
  output logic [IDX_W-1:0]        out_col_index,
  output logic signed [VAL_W-1:0] out_saddle_value,
  output logic                    out_last
);

  logic                    valid_r, valid_nxt;
  logic                    found_r, found_nxt;
  logic [IDX_W-1:0]        row_r, row_nxt;
  logic [IDX_W-1:0]        col_r, col_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic                    last_r, last_nxt;

  // Emit a hit only once the entry behind it is known
  always_comb begin
    rd.pop_one = 1'b0;
    rd.pop_two = 1'b0;
    valid_nxt  = 1'b0;
    found_nxt  = 1'b0;
    row_nxt    = '0;
    col_nxt    = '0;
    value_nxt  = '0;
    last_nxt   = 1'b0;
    if (st.has_one) begin
      if (head0.kind == ENTRY_END) begin
        // matrix without any saddle point
        valid_nxt  = 1'b1;
        last_nxt   = 1'b1;
        rd.pop_one = 1'b1;
      end else if (st.has_two) begin
        valid_nxt = 1'b1;
        found_nxt = 1'b1;
        row_nxt   = head0.row;
        col_nxt   = head0.col;
        value_nxt = head0.value;
        if (head1.kind == ENTRY_END) begin
          last_nxt   = 1'b1;
          rd.pop_two = 1'b1;
        end else begin
          rd.pop_one = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    row_r   <= row_nxt;
    col_r   <= col_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid        = valid_r;
  assign out_found        = found_r;
  assign out_row_index    = row_r;
  assign out_col_index    = col_r;
  assign out_saddle_value = value_r;
  assign out_last         = last_r;

endmodule

### design/matrix_saddle_point_finder_top.sv
// Loading accepts one element per cycle while busy is low; a scan then reads one stored
// element per cycle while busy is high, and stops early once the result limit is reached.
// The scan pauses only while the four-entry result queue is full.
// Reset (synchronous, rst_n low) clears the load position, the state and the queue; the matrix
// store and the row and column extremes are undefined until loaded.
`timescale 1ns / 1ps

module matrix_saddle_point_finder_top
  import msp_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 4
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] in_element,
  output logic                    out_valid,
  output logic                    out_found,
  output logic [IDX_W-1:0]        out_row_index,
  output logic [IDX_W-1:0]        out_col_index,
  output logic signed [VAL_W-1:0] out_saddle_value,
  output logic                    out_last
);

  queue_wr_t   q_wr;
  queue_rd_t   q_rd;
  queue_st_t   q_st;
  scan_entry_t q_head0;
  scan_entry_t q_head1;

  msp_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .element (in_element),
    .busy    (busy),
    .q_wr    (q_wr),
    .q_full  (q_st.full)
  );

  msp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .rd    (q_rd),
    .st    (q_st),
    .head0 (q_head0),
    .head1 (q_head1)
  );

  msp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .st               (q_st),
    .head0            (q_head0),
    .head1            (q_head1),
    .rd               (q_rd),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_row_index    (out_row_index),
    .out_col_index    (out_col_index),
    .out_saddle_value (out_saddle_value),
    .out_last         (out_last)
  );

endmodule

### design/msp_checker.sv
// Port-level checker for the saddle point finder, bound to the top level.
`timescale 1ns / 1ps

module msp_checker
  import msp_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic signed [VAL_W-1:0] in_element,
  input logic                    out_valid,
  input logic                    out_found,
  input logic [IDX_W-1:0]        out_row_index,
  input logic [IDX_W-1:0]        out_col_index,
  input logic signed [VAL_W-1:0] out_saddle_value,
  input logic                    out_last
);

  // Reset leaves the block ready and silent
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

  // A matrix without saddle points gives a single, final transaction
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_last)
    else $error("no-saddle transaction not marked last");

  // The no-saddle transaction carries zero position and value
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |->
      out_row_index == '0 && out_col_index == '0 && out_saddle_value == '0)
    else $error("no-saddle transaction carries non-zero fields");

  // Back-to-back saddle points of one matrix come in row-major order
  a_row_major: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found && !out_last |=>
      !out_valid ||
      ({out_row_index, out_col_index} > $past({out_row_index, out_col_index})))
    else $error("saddle points out of row-major order");

endmodule

bind matrix_saddle_point_finder_top msp_checker u_msp_checker (.*);

### bench/testbench.sv
// Self-checking bench for the matrix saddle point finder: tied, saddle-free and random matrices.
`timescale 1ns / 1ps

module testbench;
  import msp_pkg::*;

  localparam int ROWS         = 4;
  localparam int COLS         = 4;
  localparam int CELLS        = ROWS * COLS;
  localparam int HALF_PERIOD  = 6;
  localparam int DRAIN_CYCLES = 2 * CELLS + 16;

  typedef struct packed {
    logic                    found;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } saddle_report_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [VAL_W-1:0] in_element;
  logic                    out_valid;
  logic                    out_found;
  logic [IDX_W-1:0]        out_row_index;
  logic [IDX_W-1:0]        out_col_index;
  logic signed [VAL_W-1:0] out_saddle_value;
  logic                    out_last;

  // Shadow copy of the matrix, the row minima and the column maxima
  logic signed [VAL_W-1:0] stored_grid [CELLS];
  logic signed [VAL_W-1:0] row_low [ROWS];
  logic signed [VAL_W-1:0] col_high [COLS];
  int                      load_count = 0;

  // Matrix built by a test before it is sent
  logic signed [VAL_W-1:0] staged_grid [CELLS];

  saddle_report_t awaited_reports[$];
  int             mismatch_count  = 0;
  logic           steady_run      = 1'b0;

  matrix_saddle_point_finder_top #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_element      (in_element),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .out_saddle_value(out_saddle_value),
    .out_last        (out_last)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  function automatic logic signed [VAL_W-1:0] rand_value();
    logic [31:0] raw;
    raw = $urandom;
    return raw[VAL_W-1:0];
  endfunction

  function automatic logic signed [VAL_W-1:0] rand_corner();
    case ($urandom_range(0, 3))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return -16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  // Load one element into the shadow state; on the last one, queue every saddle point
  function automatic void absorb_element(input logic signed [VAL_W-1:0] value);
    int             r;
    int             c;
    int             i;
    int             j;
    int             hits;
    logic signed [VAL_W-1:0] v;
    saddle_report_t held;
    saddle_report_t rep;
    r = load_count / COLS;
    c = load_count % COLS;
    stored_grid[load_count] = value;
    if (c == 0 || value < row_low[r]) row_low[r] = value;
    if (r == 0 || value > col_high[c]) col_high[c] = value;
    if (load_count < CELLS - 1) begin
      load_count++;
      return;
    end
    load_count = 0;
    hits = 0;
    held = '0;
    // Hold each hit back one step so the final one can carry last
    for (i = 0; i < ROWS; i++) begin
      for (j = 0; j < COLS; j++) begin
        v = stored_grid[i * COLS + j];
        if (hits < RESULT_LIMIT && v == row_low[i] && v == col_high[j]) begin
          if (hits > 0) begin
            awaited_reports.push_back(held);
          end
          rep.found = 1'b1;
          rep.row   = i[IDX_W-1:0];
          rep.col   = j[IDX_W-1:0];
          rep.value = v;
          rep.last  = 1'b0;
          held = rep;
          hits++;
        end
      end
    end
    if (hits == 0) begin
      held = '0;
    end
    held.last = 1'b1;
    awaited_reports.push_back(held);
  endfunction

  // Offer one element, idling at random first outside a steady run, and wait until it is taken
  task automatic send_element(input logic signed [VAL_W-1:0] value);
    if (!steady_run) begin
      while ($urandom_range(0, 99) < 36) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start      <= 1'b1;
    in_element <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_element(value);
  endtask

  task automatic send_staged_grid();
    int k;
    for (k = 0; k < CELLS; k++) send_element(staged_grid[k]);
  endtask

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Check each result transaction against the oldest queued expectation
  always @(posedge clk) begin : check_results
    saddle_report_t want;
    if (rst_n && out_valid) begin
      if (awaited_reports.size() == 0) begin
        flag_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                out_row_index, out_col_index, out_saddle_value));
      end else begin
        want = awaited_reports.pop_front();
        compare_field("found", out_found, want.found);
        compare_field("row_index", out_row_index, want.row);
        compare_field("col_index", out_col_index, want.col);
        compare_field("saddle_value", out_saddle_value, want.value);
        compare_field("last", out_last, want.last);
      end
    end
  end

  // Equal elements everywhere: every element ties, the result limit is reached
  task automatic test_tied_limit();
    int k;
    for (k = 0; k < CELLS; k++) staged_grid[k] = 16'sh8000;
    send_staged_grid();
  endtask

  // Latin square: row minima and column maxima never meet
  task automatic test_no_saddle();
    logic signed [VAL_W-1:0] pool [4];
    int i;
    int j;
    pool[0] = 16'sh7fff;
    pool[1] = 16'sd0;
    pool[2] = -16'sd1;
    pool[3] = 16'sd5;
    for (i = 0; i < ROWS; i++)
      for (j = 0; j < COLS; j++) staged_grid[i * COLS + j] = pool[(i + j) % 4];
    send_staged_grid();
  endtask

  // Plant a saddle point: its row holds nothing lower, its column nothing higher
  task automatic stage_planted();
    int pr;
    int pc;
    int pivot;
    int i;
    int j;
    pr    = $urandom_range(0, ROWS - 1);
    pc    = $urandom_range(0, COLS - 1);
    pivot = int'($urandom_range(0, 20000)) - 10000;
    for (i = 0; i < ROWS; i++) begin
      for (j = 0; j < COLS; j++) begin
        if (i == pr && j == pc) begin
          staged_grid[i * COLS + j] = VAL_W'(pivot);
        end else if (i == pr) begin
          staged_grid[i * COLS + j] = VAL_W'(pivot + int'($urandom_range(0, 10000)));
        end else if (j == pc) begin
          staged_grid[i * COLS + j] = VAL_W'(pivot - int'($urandom_range(0, 10000)));
        end else begin
          staged_grid[i * COLS + j] = rand_value();
        end
      end
    end
  endtask

  task automatic stage_random_matrix();
    int pick;
    int k;
    logic signed [VAL_W-1:0] flat;
    pick = $urandom_range(0, 99);
    flat = rand_value();
    if (pick < 35) begin
      stage_planted();
    end else begin
      for (k = 0; k < CELLS; k++) begin
        if (pick < 55) staged_grid[k] = VAL_W'(int'($urandom_range(0, 4)) - 2);
        else if (pick < 75) staged_grid[k] = rand_value();
        else if (pick < 90) staged_grid[k] = rand_corner();
        else staged_grid[k] = flat;
      end
    end
  endtask

  // Mixed random matrices, with a stretch of back-to-back elements
  task automatic test_random_matrices();
    int made;
    made = 0;
    while (made < 15) begin
      steady_run = (made >= 4 && made < 8);
      stage_random_matrix();
      send_staged_grid();
      made++;
    end
    steady_run = 1'b0;
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_element <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_tied_limit();
    test_no_saddle();
    test_random_matrices();

    start <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
